FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the decimal fixed-point ALU.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Implication with a fixed delay, disabled during reset
`define ASSERT_DELAYED(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("assertion failed: delayed implication");

`endif

FILE: rtl/dfpa_pkg.sv
// ----------------------------------------------------------------------------
// dfpa_pkg
// Types, widths and constants of the decimal fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package dfpa_pkg;

   // operand and result field widths
   localparam int INT_W   = 32;
   localparam int FRAC_W  = 14;
   localparam int SCALE   = 10000;

   // constant divider: numerator width, quotient width, reciprocal
   localparam int DIV_W       = 33;
   localparam int QUO_W       = 20;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 33;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / SCALE);

   // bias that makes a signed integer part non-negative, a multiple of SCALE
   localparam longint BIAS_Q = ((longint'(1) << (INT_W - 1)) / SCALE) + 1;
   localparam longint BIAS   = BIAS_Q * SCALE;

   // internal datapath widths
   localparam int FS_W    = 16;           // fraction sum/difference, signed
   localparam int SPLIT_W = INT_W + 2;    // exact add/sub integer part
   localparam int AQ_W    = 21;           // floor(int/SCALE), signed
   localparam int Y_W     = 29;           // low-order partial sum of a product
   localparam int MS_W    = 37;           // cross-term sum, signed
   localparam int PROD_W  = 2 * INT_W;    // exact product integer part

   // register stages from accepted word to result strobe
   localparam int PIPE_DEPTH = 7;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_CMP
   } op_type;

   typedef enum logic [1:0] {
      ORD_LESS,
      ORD_EQUAL,
      ORD_GREATER
   } order_type;

   // exact add/sub result split into integer part and fraction
   typedef struct packed {
      logic signed [SPLIT_W-1:0] int_val;
      logic        [FRAC_W-1:0]  frac;
   } split_type;

endpackage

`default_nettype wire

FILE: rtl/decimal_fixed_point_alu_unit.sv
// Latency: a word accepted at a clock edge has its result strobed on rsp_valid
// once it has passed through every register stage of the pipeline.
// Throughput: one word per cycle, set by the 7-stage multiply/divide pipeline.
// busy is high only while reset is; the result side never stalls.
// Reset (synchronous, active high) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// decimal_fixed_point_alu_unit
// Decimal fixed-point ALU, four fractional digits: add, subtract, exact
// multiply and compare, with integer wrap and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module decimal_fixed_point_alu_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  dfpa_pkg::op_type                    req_opcode,
   input  logic signed [dfpa_pkg::INT_W-1:0]   req_a_int,
   input  logic        [dfpa_pkg::FRAC_W-1:0]  req_a_frac,
   input  logic signed [dfpa_pkg::INT_W-1:0]   req_b_int,
   input  logic        [dfpa_pkg::FRAC_W-1:0]  req_b_frac,
   output logic                                rsp_valid,
   output logic signed [dfpa_pkg::INT_W-1:0]   rsp_res_int,
   output logic        [dfpa_pkg::FRAC_W-1:0]  rsp_res_frac,
   output logic        [1:0]                   rsp_order,
   output logic                                rsp_overflow
);
   import dfpa_pkg::*;

   logic                       accept;
   logic [PIPE_DEPTH-2:0]      valid_in, valid_ff;
   op_type                     op_ff [PIPE_DEPTH-1];
   split_type                  split_s2;
   split_type                  split_ff [4];
   logic signed [PROD_W-1:0]   prod_int;
   logic [FRAC_W-1:0]          prod_frac;

   logic                       out_valid_ff;
   logic signed [INT_W-1:0]    res_int_in, res_int_ff;
   logic [FRAC_W-1:0]          res_frac_in, res_frac_ff;
   order_type                  order_in, order_ff;
   logic                       ovf_in, ovf_ff;
   split_type                  sp;

   assign busy   = reset;
   assign accept = start & ~busy;

   // datapaths
   dfpa_addsub u_addsub (
      .clock  (clock),
      .op     (req_opcode),
      .a_int  (req_a_int),
      .a_frac (req_a_frac),
      .b_int  (req_b_int),
      .b_frac (req_b_frac),
      .split  (split_s2)
   );

   dfpa_mul u_mul (
      .clock     (clock),
      .a_int     (req_a_int),
      .a_frac    (req_a_frac),
      .b_int     (req_b_int),
      .b_frac    (req_b_frac),
      .prod_int  (prod_int),
      .prod_frac (prod_frac)
   );

   // valid bits and opcode travel with the word
   assign valid_in = {valid_ff[PIPE_DEPTH-3:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[PIPE_DEPTH-2];
      end
   end

   always_ff @(posedge clock) begin
      op_ff[0] <= req_opcode;
      for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
         op_ff[i] <= op_ff[i-1];
      end
      split_ff[0] <= split_s2;
      for (int i = 1; i < 4; i++) begin
         split_ff[i] <= split_ff[i-1];
      end
   end

   // result select, wrap and overflow
   always_comb begin
      sp          = split_ff[3];
      res_int_in  = '0;
      res_frac_in = '0;
      order_in    = ORD_LESS;
      ovf_in      = 1'b0;
      case (op_ff[PIPE_DEPTH-2]) inside
         OP_ADD, OP_SUB: begin
            res_int_in  = sp.int_val[INT_W-1:0];
            res_frac_in = sp.frac;
            ovf_in      = !((sp.int_val[SPLIT_W-1:INT_W-1] == '0)
                         || (sp.int_val[SPLIT_W-1:INT_W-1] == '1));
         end
         OP_MUL: begin
            res_int_in  = prod_int[INT_W-1:0];
            res_frac_in = prod_frac;
            ovf_in      = !((prod_int[PROD_W-1:INT_W-1] == '0)
                         || (prod_int[PROD_W-1:INT_W-1] == '1));
         end
         OP_CMP: begin
            if (sp.int_val < 0) begin
               order_in = ORD_LESS;
            end else if ((sp.int_val == 0) && (sp.frac == '0)) begin
               order_in = ORD_EQUAL;
            end else begin
               order_in = ORD_GREATER;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_int_ff  <= res_int_in;
      res_frac_ff <= res_frac_in;
      order_ff    <= order_in;
      ovf_ff      <= ovf_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_res_int  = res_int_ff;
   assign rsp_res_frac = res_frac_ff;
   assign rsp_order    = order_ff;
   assign rsp_overflow = ovf_ff;

   // checks
   `ASSERT_DELAYED(a_fixed_latency, clock, reset, start && !busy, PIPE_DEPTH, rsp_valid)
   `ASSERT_IMPLIES(a_no_stray_word, clock, reset, rsp_valid, $past(start && !busy, PIPE_DEPTH))
   `ASSERT_IMPLIES(a_frac_in_range, clock, reset, rsp_valid, rsp_res_frac < FRAC_W'(SCALE))
   `ASSERT_IMPLIES(a_order_alone, clock, reset, rsp_valid && (rsp_res_int != 0 || rsp_res_frac != 0 || rsp_overflow), rsp_order == ORD_LESS)

endmodule

`default_nettype wire

FILE: rtl/dfpa_div10k.sv
// ----------------------------------------------------------------------------
// dfpa_div10k
// Two-stage unsigned divide by 10000: reciprocal multiply, then one
// compare-and-subtract correction. Quotient and remainder are registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpa_div10k (
   input  logic                          clock,
   input  logic [dfpa_pkg::DIV_W-1:0]    num,
   output logic [dfpa_pkg::QUO_W-1:0]    quo,
   output logic [dfpa_pkg::FRAC_W-1:0]   rem
);
   import dfpa_pkg::*;

   localparam int PW = DIV_W + RECIP_W;

   logic [PW-1:0]     prod;
   logic [QUO_W-1:0]  est_in, est_ff;
   logic [DIV_W-1:0]  num_ff;
   logic [DIV_W:0]    back;
   logic [DIV_W:0]    diff;
   logic [FRAC_W:0]   r;
   logic [QUO_W-1:0]  quo_in, quo_ff;
   logic [FRAC_W-1:0] rem_in, rem_ff;

   // estimate: never above the true quotient, at most one below
   always_comb begin
      prod   = PW'(num) * PW'(RECIP);
      est_in = prod[RECIP_SHIFT +: QUO_W];
   end

   // correction: remainder of the estimate lies in 0 .. 2*SCALE-1
   always_comb begin
      back = (DIV_W+1)'(est_ff) * (DIV_W+1)'(SCALE);
      diff = {1'b0, num_ff} - back;
      r    = diff[FRAC_W:0];
      if (r >= (FRAC_W+1)'(SCALE)) begin
         quo_in = est_ff + QUO_W'(1);
         rem_in = FRAC_W'(r - (FRAC_W+1)'(SCALE));
      end else begin
         quo_in = est_ff;
         rem_in = r[FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      est_ff <= est_in;
      num_ff <= num;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/dfpa_addsub.sv
// ----------------------------------------------------------------------------
// dfpa_addsub
// Add/subtract front end: integer and fraction parts are combined
// separately, then the fraction carry or borrow is folded into the integer.
// Compare uses the difference. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpa_addsub (
   input  logic                                clock,
   input  dfpa_pkg::op_type                    op,
   input  logic signed [dfpa_pkg::INT_W-1:0]   a_int,
   input  logic        [dfpa_pkg::FRAC_W-1:0]  a_frac,
   input  logic signed [dfpa_pkg::INT_W-1:0]   b_int,
   input  logic        [dfpa_pkg::FRAC_W-1:0]  b_frac,
   output dfpa_pkg::split_type                 split
);
   import dfpa_pkg::*;

   logic signed [INT_W:0]  is_in, is_ff;
   logic signed [FS_W-1:0] fs_in, fs_ff;
   logic signed [2:0]      carry;
   logic signed [FS_W-1:0] fix;
   logic signed [FS_W-1:0] frac_full;
   split_type              split_in, split_ff;

   // stage 1: integer and fraction sums (difference for sub and compare)
   always_comb begin
      if (op == OP_ADD) begin
         is_in = {a_int[INT_W-1], a_int} + {b_int[INT_W-1], b_int};
         fs_in = {2'b00, a_frac} + {2'b00, b_frac};
      end else begin
         is_in = {a_int[INT_W-1], a_int} - {b_int[INT_W-1], b_int};
         fs_in = {2'b00, a_frac} - {2'b00, b_frac};
      end
   end

   // stage 2: floor(fraction / SCALE) is small, pick it by compares
   always_comb begin
      if (fs_ff >= $signed(FS_W'(3 * SCALE))) begin
         carry = 3'sd3;
      end else if (fs_ff >= $signed(FS_W'(2 * SCALE))) begin
         carry = 3'sd2;
      end else if (fs_ff >= $signed(FS_W'(SCALE))) begin
         carry = 3'sd1;
      end else if (fs_ff >= $signed(FS_W'(0))) begin
         carry = 3'sd0;
      end else if (fs_ff >= $signed(FS_W'(-SCALE))) begin
         carry = -3'sd1;
      end else begin
         carry = -3'sd2;
      end
      fix              = FS_W'(carry * SCALE);
      frac_full        = fs_ff - fix;
      split_in.frac    = frac_full[FRAC_W-1:0];
      split_in.int_val = {is_ff[INT_W], is_ff} + {{(INT_W-1){carry[2]}}, carry};
   end

   always_ff @(posedge clock) begin
      is_ff    <= is_in;
      fs_ff    <= fs_in;
      split_ff <= split_in;
   end

   assign split = split_ff;

endmodule

`default_nettype wire

FILE: rtl/dfpa_mul.sv
// ----------------------------------------------------------------------------
// dfpa_mul
// Exact fixed-point multiply. With a = ai*10000 + af and ai = aq*10000 + ar
// the product floor-divided by 10000 splits into
//    int  = ai*bi + aq*bf + bq*af + floor(Y/10000)
//    frac = Y mod 10000,   Y = ar*bf + br*af + floor(af*bf/10000)
// so only narrow values ever pass through a divider. Six register stages;
// the integer part leaves as the sum of two registered terms.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpa_mul (
   input  logic                                clock,
   input  logic signed [dfpa_pkg::INT_W-1:0]   a_int,
   input  logic        [dfpa_pkg::FRAC_W-1:0]  a_frac,
   input  logic signed [dfpa_pkg::INT_W-1:0]   b_int,
   input  logic        [dfpa_pkg::FRAC_W-1:0]  b_frac,
   output logic signed [dfpa_pkg::PROD_W-1:0]  prod_int,
   output logic        [dfpa_pkg::FRAC_W-1:0]  prod_frac
);
   import dfpa_pkg::*;

   // stage 1
   logic [DIV_W:0]            ua_ext, ub_ext;
   logic [DIV_W-1:0]          ua_ff, ub_ff;
   logic [2*FRAC_W-1:0]       pf_ff;
   logic signed [PROD_W-1:0]  ab1_ff, ab2_ff, ab3_ff, ab4_ff;
   logic [FRAC_W-1:0]         af1_ff, bf1_ff, af2_ff, bf2_ff, af3_ff, bf3_ff;

   // divider outputs, stage 3
   logic [QUO_W-1:0]          qa, qb, qc;
   logic [FRAC_W-1:0]         ra, rb;

   // stage 4
   logic signed [AQ_W-1:0]    aq, bq;
   logic [Y_W-1:0]            y_in, y_ff;
   logic signed [MS_W-1:0]    ms_in, ms_ff;

   // stage 5 and 6
   logic signed [PROD_W-1:0]  part_in, part5_ff, part6_ff;
   logic [QUO_W-1:0]          qy;
   logic [FRAC_W-1:0]         ry;

   // bias the integer parts so the dividers see unsigned numerators
   always_comb begin
      ua_ext = {{(DIV_W+1-INT_W){a_int[INT_W-1]}}, a_int} + (DIV_W+1)'(BIAS);
      ub_ext = {{(DIV_W+1-INT_W){b_int[INT_W-1]}}, b_int} + (DIV_W+1)'(BIAS);
   end

   always_ff @(posedge clock) begin
      ua_ff  <= ua_ext[DIV_W-1:0];
      ub_ff  <= ub_ext[DIV_W-1:0];
      pf_ff  <= (2*FRAC_W)'(a_frac) * (2*FRAC_W)'(b_frac);
      ab1_ff <= PROD_W'(a_int) * PROD_W'(b_int);
      af1_ff <= a_frac;
      bf1_ff <= b_frac;
      af2_ff <= af1_ff;
      bf2_ff <= bf1_ff;
      af3_ff <= af2_ff;
      bf3_ff <= bf2_ff;
      ab2_ff <= ab1_ff;
      ab3_ff <= ab2_ff;
      ab4_ff <= ab3_ff;
   end

   // stages 2-3: floor(ai/SCALE), floor(bi/SCALE), floor(af*bf/SCALE)
   dfpa_div10k u_div_a (
      .clock (clock),
      .num   (ua_ff),
      .quo   (qa),
      .rem   (ra)
   );

   dfpa_div10k u_div_b (
      .clock (clock),
      .num   (ub_ff),
      .quo   (qb),
      .rem   (rb)
   );

   dfpa_div10k u_div_p (
      .clock (clock),
      .num   (DIV_W'(pf_ff)),
      .quo   (qc),
      .rem   ()
   );

   // stage 4: cross terms and low-order sum
   always_comb begin
      aq    = $signed({1'b0, qa}) - AQ_W'(BIAS_Q);
      bq    = $signed({1'b0, qb}) - AQ_W'(BIAS_Q);
      y_in  = Y_W'(ra) * Y_W'(bf3_ff) + Y_W'(rb) * Y_W'(af3_ff) + Y_W'(qc);
      ms_in = MS_W'(aq) * MS_W'($signed({1'b0, bf3_ff}))
            + MS_W'(bq) * MS_W'($signed({1'b0, af3_ff}));
   end

   always_ff @(posedge clock) begin
      y_ff  <= y_in;
      ms_ff <= ms_in;
   end

   // stages 5-6: split the low-order sum, gather the high-order terms
   dfpa_div10k u_div_y (
      .clock (clock),
      .num   (DIV_W'(y_ff)),
      .quo   (qy),
      .rem   (ry)
   );

   assign part_in = ab4_ff + PROD_W'(ms_ff);

   always_ff @(posedge clock) begin
      part5_ff <= part_in;
      part6_ff <= part5_ff;
   end

   assign prod_int  = part6_ff + PROD_W'(qy);
   assign prod_frac = ry;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimal fixed-point ALU. Directed words cover
// the field extremes, every opcode, the wrap and overflow boundaries and
// fractions above 9999; random words follow, with random gaps between words.
// A scoreboard predicts each accepted word on exact 128-bit scaled values and
// checks every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import dfpa_pkg::*;

   typedef logic signed [127:0] wide_type;

   localparam logic signed [INT_W-1:0] INT_FIELD_MAX = 32'sh7fff_ffff;
   localparam logic signed [INT_W-1:0] INT_FIELD_MIN = 32'sh8000_0000;
   localparam wide_type SCALE_WIDE   = 128'sd10000;
   localparam wide_type INT_WIDE_MAX = 128'sd2147483647;
   localparam wide_type INT_WIDE_MIN = -(128'sd2147483648);
   localparam int    WATCHDOG_LIMIT = 300;
   localparam int    DRAIN_CYCLES   = PIPE_DEPTH + 8;
   localparam int    RANDOM_WORDS   = 630;

   // expected contents of one result word
   typedef struct {
      logic signed [INT_W-1:0]  int_part;
      logic        [FRAC_W-1:0] frac;
      order_type                order_val;
      logic                     ovf;
   } alu_result_type;

   // --------------------------------------------------------------------------
   // Scoreboard: predicts ALU results and checks them in order
   // --------------------------------------------------------------------------
   class alu_result_tracker;
      alu_result_type pending_results[$];
      int unsigned    mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // floor division by the decimal scale, remainder always 0..9999
      function void floor_split(input wide_type num, output wide_type quo,
                                output wide_type rem);
         quo = num / SCALE_WIDE;
         rem = num % SCALE_WIDE;
         if (rem < 0) begin
            quo = quo - 1;
            rem = rem + SCALE_WIDE;
         end
      endfunction

      function alu_result_type predict_word(op_type op,
                                            logic signed [INT_W-1:0] a_int,
                                            logic [FRAC_W-1:0] a_frac,
                                            logic signed [INT_W-1:0] b_int,
                                            logic [FRAC_W-1:0] b_frac);
         wide_type       sa, sb, exact, quo, rem;
         alu_result_type r;
         // scaled values; fractions above 9999 carry into the integer part
         sa = wide_type'(a_int) * SCALE_WIDE + wide_type'(a_frac);
         sb = wide_type'(b_int) * SCALE_WIDE + wide_type'(b_frac);
         r.int_part  = '0;
         r.frac      = '0;
         r.order_val = ORD_LESS;
         r.ovf       = 1'b0;
         if (op == OP_CMP) begin
            r.order_val = (sa < sb) ? ORD_LESS : ((sa == sb) ? ORD_EQUAL : ORD_GREATER);
            return r;
         end
         if (op == OP_MUL) begin
            // product carries eight fraction digits, drop four with floor
            floor_split(sa * sb, exact, rem);
         end else begin
            exact = (op == OP_ADD) ? sa + sb : sa - sb;
         end
         floor_split(exact, quo, rem);
         r.int_part = quo[INT_W-1:0];
         r.frac     = rem[FRAC_W-1:0];
         r.ovf      = (quo > INT_WIDE_MAX) || (quo < INT_WIDE_MIN);
         return r;
      endfunction

      function void note_request(op_type op,
                                 logic signed [INT_W-1:0] a_int,
                                 logic [FRAC_W-1:0] a_frac,
                                 logic signed [INT_W-1:0] b_int,
                                 logic [FRAC_W-1:0] b_frac);
         pending_results.push_back(predict_word(op, a_int, a_frac, b_int, b_frac));
      endfunction

      function void report_mismatch(string field, longint exp_val, longint act_val);
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, exp_val, act_val);
         mismatch_count++;
      endfunction

      function void check_result(logic signed [INT_W-1:0] res_int,
                                 logic [FRAC_W-1:0] res_frac,
                                 logic [1:0] res_order,
                                 logic res_ovf);
         alu_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result word, res_int", 0, res_int);
            return;
         end
         want = pending_results.pop_front();
         if (res_int !== want.int_part)
            report_mismatch("res_int", want.int_part, res_int);
         if (res_frac !== want.frac)
            report_mismatch("res_frac", want.frac, res_frac);
         if (res_order !== want.order_val)
            report_mismatch("order", want.order_val, res_order);
         if (res_ovf !== want.ovf)
            report_mismatch("overflow", want.ovf, res_ovf);
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // Clock, reset and DUT
   // --------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   op_type                   req_opcode = OP_ADD;
   logic signed [INT_W-1:0]  req_a_int  = '0;
   logic        [FRAC_W-1:0] req_a_frac = '0;
   logic signed [INT_W-1:0]  req_b_int  = '0;
   logic        [FRAC_W-1:0] req_b_frac = '0;
   logic                     rsp_valid;
   logic signed [INT_W-1:0]  rsp_res_int;
   logic        [FRAC_W-1:0] rsp_res_frac;
   logic        [1:0]        rsp_order;
   logic                     rsp_overflow;

   alu_result_tracker tracker = new();
   int unsigned       idle_cycles = 0;
   bit                no_idle = 1'b0;

   always #2 clock = ~clock;

   decimal_fixed_point_alu_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_a_int    (req_a_int),
      .req_a_frac   (req_a_frac),
      .req_b_int    (req_b_int),
      .req_b_frac   (req_b_frac),
      .rsp_valid    (rsp_valid),
      .rsp_res_int  (rsp_res_int),
      .rsp_res_frac (rsp_res_frac),
      .rsp_order    (rsp_order),
      .rsp_overflow (rsp_overflow)
   );

   // --------------------------------------------------------------------------
   // Monitor: note accepted words, check strobed results
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            tracker.note_request(req_opcode, req_a_int, req_a_frac, req_b_int, req_b_frac);
         if (rsp_valid)
            tracker.check_result(rsp_res_int, rsp_res_frac, rsp_order, rsp_overflow);
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Driver
   // --------------------------------------------------------------------------
   // present one word after a random gap (none while no_idle is set), return at the edge that takes it
   task automatic send_word(input op_type op,
                            input logic signed [INT_W-1:0] a_int,
                            input logic [FRAC_W-1:0] a_frac,
                            input logic signed [INT_W-1:0] b_int,
                            input logic [FRAC_W-1:0] b_frac);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_opcode <= op;
      req_a_int  <= a_int;
      req_a_frac <= a_frac;
      req_b_int  <= b_int;
      req_b_frac <= b_frac;
      do @(posedge clock); while (busy);
   endtask

   // integer parts: full range, small, near both extremes
   function automatic logic signed [INT_W-1:0] draw_int();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 200) - 100;
         2: return INT_FIELD_MAX - $urandom_range(0, 3);
         3: return INT_FIELD_MIN + $urandom_range(0, 3);
         default: return $urandom_range(0, 60000) - 30000;
      endcase
   endfunction

   // fractions: mostly legal, some at the edges and above 9999
   function automatic logic [FRAC_W-1:0] draw_frac();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FRAC_W'(9999);
         2: return FRAC_W'($urandom_range(10000, 16383));
         default: return FRAC_W'($urandom_range(0, 9999));
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: boundaries, carries, signs, fractions above 9999
      send_word(OP_ADD, INT_FIELD_MAX, 9999, 0, 1);
      send_word(OP_ADD, INT_FIELD_MIN, 0, -1, 9999);
      send_word(OP_ADD, INT_FIELD_MAX, 0, INT_FIELD_MAX, 0);
      send_word(OP_ADD, -5, 16383, 3, 16383);
      send_word(OP_ADD, 0, 0, 0, 0);
      send_word(OP_SUB, INT_FIELD_MIN, 0, 0, 1);
      send_word(OP_SUB, INT_FIELD_MAX, 9999, INT_FIELD_MIN, 0);
      send_word(OP_SUB, 0, 0, 0, 1);
      send_word(OP_SUB, 7, 2500, 7, 2500);
      send_word(OP_MUL, 0, 1, 0, 1);
      send_word(OP_MUL, -1, 9999, 0, 1);
      send_word(OP_MUL, INT_FIELD_MAX, 9999, INT_FIELD_MAX, 9999);
      send_word(OP_MUL, INT_FIELD_MIN, 0, INT_FIELD_MIN, 0);
      send_word(OP_MUL, INT_FIELD_MIN, 0, 1, 0);
      send_word(OP_MUL, -3, 5000, 2, 2500);
      send_word(OP_MUL, 12345, 16383, -1, 0);
      send_word(OP_MUL, INT_FIELD_MAX, 9999, -1, 16383);
      send_word(OP_CMP, 1, 10000, 2, 0);
      send_word(OP_CMP, INT_FIELD_MIN, 0, INT_FIELD_MAX, 9999);
      send_word(OP_CMP, INT_FIELD_MAX, 16383, INT_FIELD_MAX, 9999);
      send_word(OP_CMP, -1, 9999, 0, 0);
      send_word(OP_CMP, 0, 0, 0, 0);

      // random words, with stretches of back-to-back issue
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 50 == 0)
            no_idle = ($urandom_range(0, 2) == 0);
         send_word(op_type'($urandom_range(0, 3)), draw_int(), draw_frac(),
                   draw_int(), draw_frac());
      end
      start <= 1'b0;

      // drain the pipeline, then allow for any stray strobe
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
